FILE: hdl/lpwc_pkg.sv
// Shared types, register map and pulse length windows of the light pulse width classifier.
`timescale 1ns / 1ps
`default_nettype none

package lpwc_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned GAP_W      = 26;
    localparam int unsigned SYMBOL_W   = 4;
    localparam int unsigned NUM_WIN    = 8;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;

    // Register indexes, byte address is four times the index
    localparam logic [REG_IDX_W-1:0] REG_MEASURE_ENABLE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_GAP       = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_GAP     = 2'd3;

    // Register reset values
    localparam logic                RST_MEASURE_ENABLE  = 1'b0;
    localparam logic [SAMPLE_W-1:0] RST_LIGHT_THRESHOLD = 12'd2750;
    localparam logic [GAP_W-1:0]    RST_START_GAP       = 26'd10000;
    localparam logic [GAP_W-1:0]    RST_RELEASE_GAP     = 26'd500;

    // Fixed offset taken off every measured length
    localparam logic [TIME_W-1:0] PULSE_OFFSET_US = 32'd15000;

    // Open length windows, symbol is window index plus one
    localparam logic [TIME_W-1:0] WIN_LO [NUM_WIN] = '{
        32'd25000, 32'd50000, 32'd70000, 32'd100000,
        32'd126000, 32'd150000, 32'd175000, 32'd200000
    };
    localparam logic [TIME_W-1:0] WIN_HI [NUM_WIN] = '{
        32'd30000, 32'd55000, 32'd80000, 32'd105000,
        32'd129000, 32'd155000, 32'd180000, 32'd205000
    };

    typedef struct packed {
        logic                measure_enable;
        logic [SAMPLE_W-1:0] light_threshold;
        logic [GAP_W-1:0]    start_gap_us;
        logic [GAP_W-1:0]    release_gap_us;
    } t_cfg;

    // Pick the first window that holds the length, else keep the previous symbol
    function automatic logic [SYMBOL_W-1:0] classify(input logic [TIME_W-1:0] len,
                                                      input logic [SYMBOL_W-1:0] prev);
        logic [SYMBOL_W-1:0] sym;
        logic                found;
        sym   = prev;
        found = 1'b0;
        for (int w = 0; w < NUM_WIN; w++) begin
            if (!found && (len > WIN_LO[w]) && (len < WIN_HI[w])) begin
                sym   = SYMBOL_W'(w + 1);
                found = 1'b1;
            end
        end
        return sym;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lpwc_regs.sv
// Configuration register file of the light pulse width classifier behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module lpwc_regs
    import lpwc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.measure_enable  <= RST_MEASURE_ENABLE;
            r_cfg.light_threshold <= RST_LIGHT_THRESHOLD;
            r_cfg.start_gap_us    <= RST_START_GAP;
            r_cfg.release_gap_us  <= RST_RELEASE_GAP;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MEASURE_ENABLE:  r_cfg.measure_enable  <= pwdata[0];
                REG_LIGHT_THRESHOLD: r_cfg.light_threshold <= pwdata[SAMPLE_W-1:0];
                REG_START_GAP:       r_cfg.start_gap_us    <= pwdata[GAP_W-1:0];
                REG_RELEASE_GAP:     r_cfg.release_gap_us  <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_MEASURE_ENABLE:  prdata = APB_DATA_W'(r_cfg.measure_enable);
            REG_LIGHT_THRESHOLD: prdata = APB_DATA_W'(r_cfg.light_threshold);
            REG_START_GAP:       prdata = APB_DATA_W'(r_cfg.start_gap_us);
            REG_RELEASE_GAP:     prdata = APB_DATA_W'(r_cfg.release_gap_us);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/lpwc_core.sv
// Input register, pulse tracking state, classifier and result register.
`timescale 1ns / 1ps
`default_nettype none

module lpwc_core
    import lpwc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [TIME_W-1:0]   i_time_us,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [TIME_W-1:0]   o_pulse_length_us,
    output logic      [SYMBOL_W-1:0] o_symbol,
    output logic                     o_symbol_changed
);

    // Input stage
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic [TIME_W-1:0]   r_in_time;

    // Pulse tracking state
    logic [TIME_W-1:0]   r_last_bright;
    logic [TIME_W-1:0]   r_start;
    logic                r_closed;
    logic [SYMBOL_W-1:0] r_sym;

    // Result stage
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_len;
    logic [SYMBOL_W-1:0] r_out_symbol;
    logic                r_out_changed;

    logic                fire;
    logic                bright;
    logic [TIME_W-1:0]   elapsed;
    logic                start_pulse;
    logic                emit;
    logic [TIME_W-1:0]   len;
    logic [SYMBOL_W-1:0] n_sym;

    // Process the held word when the result slot is free or being drained
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    assign bright      = r_in_sample > i_cfg.light_threshold;
    assign elapsed     = r_in_time - r_last_bright;
    assign start_pulse = bright && i_cfg.measure_enable
                         && (elapsed > TIME_W'(i_cfg.start_gap_us));
    assign emit        = !bright && i_cfg.measure_enable
                         && (elapsed > TIME_W'(i_cfg.release_gap_us)) && !r_closed;
    assign len         = r_in_time - r_start - PULSE_OFFSET_US;
    assign n_sym       = classify(len, r_sym);

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_sample <= i_sample;
            r_in_time   <= i_time_us;
        end
    end

    // Advance the pulse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_bright <= '0;
            r_start       <= '0;
            r_closed      <= 1'b0;
            r_sym         <= '0;
        end else if (fire) begin
            if (bright) begin
                r_last_bright <= r_in_time;
            end
            if (start_pulse) begin
                r_start  <= r_in_time;
                r_closed <= 1'b0;
            end
            if (emit) begin
                r_closed <= 1'b1;
                r_sym    <= n_sym;
            end
        end
    end

    // Load the result word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_len     <= len;
            r_out_symbol  <= n_sym;
            r_out_changed <= n_sym != r_sym;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_pulse_length_us = r_out_len;
    assign o_symbol          = r_out_symbol;
    assign o_symbol_changed  = r_out_changed;

    // A waiting result always carries the current symbol
    a_out_sym_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_symbol == r_sym))
        else $error("waiting result symbol differs from current symbol");

    // A change can only lead to a real symbol
    a_changed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_changed) |-> (r_out_symbol != '0))
        else $error("symbol change reported towards symbol zero");

    // Symbol never leaves the window range
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym <= SYMBOL_W'(NUM_WIN))
        else $error("symbol out of range");

    // A measured pulse is closed afterwards
    a_closed_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit) |=> (r_closed && r_out_valid))
        else $error("pulse not closed after measurement");

endmodule

`default_nettype wire

FILE: hdl/light_pulse_width_classifier.sv
// Top level of the light pulse width classifier: register file and measuring core.
// A closing sample enters the input register, then its result word the result register.
// Throughput: one sample per cycle; input register and result register part the two sides.
// A sample is held back only while a result word waits and the sink is not ready.
// Reset (synchronous, active low) clears pulse state, symbol and handshakes and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module light_pulse_width_classifier
    import lpwc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic [TIME_W-1:0]     i_time_us,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [TIME_W-1:0]     o_pulse_length_us,
    output logic      [SYMBOL_W-1:0]   o_symbol,
    output logic                       o_symbol_changed
);

    t_cfg cfg;

    lpwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpwc_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_time_us         (i_time_us),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pulse_length_us (o_pulse_length_us),
        .o_symbol          (o_symbol),
        .o_symbol_changed  (o_symbol_changed)
    );

endmodule

`default_nettype wire

FILE: tb/sv/lpwc_result_checker.sv
// Result checker for the light pulse width classifier: predicts pulse words and compares them.
`timescale 1ns / 1ps

module lpwc_result_checker
    import lpwc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    input  wire logic                  i_valid,
    input  wire logic                  o_ready,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic [TIME_W-1:0]     i_time_us,
    input  wire logic                  o_valid,
    input  wire logic                  i_ready,
    input  wire logic [TIME_W-1:0]     o_pulse_length_us,
    input  wire logic [SYMBOL_W-1:0]   o_symbol,
    input  wire logic                  o_symbol_changed,
    output int                         o_fail_count,
    output int                         o_waiting
);

    typedef struct packed {
        logic [TIME_W-1:0]   length_us;
        logic [SYMBOL_W-1:0] symbol;
        logic                changed;
    } t_pulse_word;

    // Own copy of the registers and of the measuring state
    t_cfg                regs;
    logic [TIME_W-1:0]   last_bright_us;
    logic [TIME_W-1:0]   pulse_start_us;
    logic                pulse_closed;
    logic [SYMBOL_W-1:0] symbol_now;

    t_pulse_word awaited_words[$];
    t_pulse_word fresh;
    t_pulse_word oldest;
    logic [TIME_W-1:0] elapsed_us;
    int          win;
    int          fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.measure_enable  = RST_MEASURE_ENABLE;
            regs.light_threshold = RST_LIGHT_THRESHOLD;
            regs.start_gap_us    = RST_START_GAP;
            regs.release_gap_us  = RST_RELEASE_GAP;
            last_bright_us       = '0;
            pulse_start_us       = '0;
            pulse_closed         = 1'b0;
            symbol_now           = '0;
            awaited_words.delete();
        end else begin
            // Track register writes, keeping only the bits each register holds
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_MEASURE_ENABLE:  regs.measure_enable  = pwdata[0];
                    REG_LIGHT_THRESHOLD: regs.light_threshold = pwdata[SAMPLE_W-1:0];
                    REG_START_GAP:       regs.start_gap_us    = pwdata[GAP_W-1:0];
                    REG_RELEASE_GAP:     regs.release_gap_us  = pwdata[GAP_W-1:0];
                    default: ;
                endcase
            end

            // Compare a delivered result word with the oldest prediction
            if (o_valid && i_ready) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with nothing awaited: length %0d symbol %0d changed %0d",
                           o_pulse_length_us, o_symbol, o_symbol_changed);
                    fails++;
                end else begin
                    oldest = awaited_words.pop_front();
                    if (o_pulse_length_us !== oldest.length_us) begin
                        $error("pulse_length_us: expected %0d, got %0d",
                               oldest.length_us, o_pulse_length_us);
                        fails++;
                    end
                    if (o_symbol !== oldest.symbol) begin
                        $error("symbol: expected %0d, got %0d", oldest.symbol, o_symbol);
                        fails++;
                    end
                    if (o_symbol_changed !== oldest.changed) begin
                        $error("symbol_changed: expected %0d, got %0d",
                               oldest.changed, o_symbol_changed);
                        fails++;
                    end
                end
            end

            // Advance the measuring state with an accepted sample word
            if (i_valid && o_ready) begin
                elapsed_us = i_time_us - last_bright_us;
                if (i_sample > regs.light_threshold) begin
                    if (regs.measure_enable && elapsed_us > TIME_W'(regs.start_gap_us)) begin
                        pulse_start_us = i_time_us;
                        pulse_closed   = 1'b0;
                    end
                    last_bright_us = i_time_us;
                end else if (regs.measure_enable && !pulse_closed &&
                             elapsed_us > TIME_W'(regs.release_gap_us)) begin
                    fresh.length_us = i_time_us - pulse_start_us - PULSE_OFFSET_US;
                    // Scan downwards so the lowest matching window wins
                    fresh.symbol = symbol_now;
                    for (win = NUM_WIN - 1; win >= 0; win--) begin
                        if (fresh.length_us > WIN_LO[win] && fresh.length_us < WIN_HI[win]) begin
                            fresh.symbol = SYMBOL_W'(win + 1);
                        end
                    end
                    fresh.changed = (fresh.symbol != symbol_now);
                    symbol_now    = fresh.symbol;
                    pulse_closed  = 1'b1;
                    awaited_words.push_back(fresh);
                end
            end
        end
        o_fail_count <= fails;
        o_waiting    <= awaited_words.size();
    end

endmodule

FILE: tb/sv/tb_light_pulse_width_classifier.sv
// Testbench top for the light pulse width classifier: stimulus, register set-up and verdict.
`timescale 1ns / 1ps

module tb_light_pulse_width_classifier;
    import lpwc_pkg::*;

    localparam int unsigned  RANDOM_SAMPLES = 750;
    localparam int unsigned  IDLE_LIMIT     = 1000;
    localparam logic [GAP_W-1:0] GAP_MAX    = 26'd65535000;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic                  i_valid   = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample  = '0;
    logic [TIME_W-1:0]     i_time_us = '0;
    logic                  i_ready   = 1'b0;

    wire [APB_DATA_W-1:0] prdata;
    wire                  pready;
    wire                  o_ready;
    wire                  o_valid;
    wire [TIME_W-1:0]     o_pulse_length_us;
    wire [SYMBOL_W-1:0]   o_symbol;
    wire                  o_symbol_changed;
    int                   fail_count;
    int                   waiting;

    // Register values as last written, used to shape the sample words
    logic                cur_enable;
    logic [SAMPLE_W-1:0] cur_threshold    = RST_LIGHT_THRESHOLD;
    logic [GAP_W-1:0]    cur_start_gap    = RST_START_GAP;
    logic [GAP_W-1:0]    cur_release_gap  = RST_RELEASE_GAP;
    logic [TIME_W-1:0]   clock_us         = '0;
    int                  burst_left       = 0;
    bit                  gaps_on          = 1'b1;
    int                  samples_sent     = 0;
    int                  idle_cycles      = 0;
    logic [31:0]         stall_mask       = '1;
    logic [4:0]          stall_pos        = '0;

    light_pulse_width_classifier i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_time_us         (i_time_us),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pulse_length_us (o_pulse_length_us),
        .o_symbol          (o_symbol),
        .o_symbol_changed  (o_symbol_changed)
    );

    lpwc_result_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_time_us         (i_time_us),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pulse_length_us (o_pulse_length_us),
        .o_symbol          (o_symbol),
        .o_symbol_changed  (o_symbol_changed),
        .o_fail_count      (fail_count),
        .o_waiting         (waiting)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result side on a rotating mask, reloaded each time the mask position wraps
    always @(posedge i_clk) begin
        stall_pos <= stall_pos + 1'b1;
        if (stall_pos == 5'd31) begin
            stall_mask <= ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
        end
        i_ready <= stall_mask[stall_pos];
    end

    // Drop the run when no word or register access moves for too long
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
                     (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one sample word, after a random gap when gaps are on and the burst has run out
    task automatic put_sample(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] stamp);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 20);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_valid   <= 1'b1;
        i_sample  <= level;
        i_time_us <= stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        samples_sent++;
    endtask

    // Drain: stop offering words and wait until every awaited result has come
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all four registers, optionally with junk above each register's width
    task automatic configure(input logic en, input logic [SAMPLE_W-1:0] thr,
                             input logic [GAP_W-1:0] sg, input logic [GAP_W-1:0] rg,
                             input bit junk);
        logic [APB_DATA_W-1:0] high_junk;
        high_junk = junk ? $urandom : '0;
        write_reg(REG_MEASURE_ENABLE, {high_junk[APB_DATA_W-1:1], en});
        write_reg(REG_LIGHT_THRESHOLD, {high_junk[APB_DATA_W-1:SAMPLE_W], thr});
        write_reg(REG_START_GAP, {high_junk[APB_DATA_W-1:GAP_W], sg});
        write_reg(REG_RELEASE_GAP, {high_junk[APB_DATA_W-1:GAP_W], rg});
        cur_enable      = en;
        cur_threshold   = thr;
        cur_start_gap   = sg;
        cur_release_gap = rg;
    endtask

    function automatic logic [SAMPLE_W-1:0] bright_level();
        if (cur_threshold == '1) return '1;
        return SAMPLE_W'($urandom_range(int'(cur_threshold) + 1, 4095));
    endfunction

    function automatic logic [SAMPLE_W-1:0] dark_level();
        return SAMPLE_W'($urandom_range(0, int'(cur_threshold)));
    endfunction

    // One bright word then the closing dark word, with a quiet stretch after
    task automatic send_bare_pulse(input logic [TIME_W-1:0] len);
        put_sample(cur_threshold + 1'b1, clock_us);
        put_sample(SAMPLE_W'($urandom_range(0, int'(cur_threshold))),
                   clock_us + PULSE_OFFSET_US + len);
        clock_us = clock_us + PULSE_OFFSET_US + len + 32'd20000;
    endtask

    // Optional dark word, quiet gap, bright run, optional early dark word, closing dark word, optional later one
    task automatic run_pulse();
        logic [TIME_W-1:0] len;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] ob;
        logic [TIME_W-1:0] step;
        int                pick;
        int                n;
        clock_us = clock_us + cur_start_gap + $urandom_range(1, 20000);
        if ($urandom_range(0, 2) == 0) put_sample(dark_level(), clock_us - $urandom_range(0, 1000));
        t0   = clock_us;
        pick = $urandom_range(0, 9);
        if (pick < NUM_WIN) len = $urandom_range(WIN_LO[pick], WIN_HI[pick]);
        else                len = $urandom_range(0, 230000);
        dur = len + PULSE_OFFSET_US;
        put_sample(bright_level(), t0);
        ob   = '0;
        n    = 0;
        step = $urandom_range(cur_start_gap / 2, cur_start_gap);
        while (n < 8 && ob + step + cur_release_gap < dur) begin
            ob = ob + step;
            put_sample(bright_level(), t0 + ob);
            n++;
            step = $urandom_range(cur_start_gap / 2, cur_start_gap);
        end
        // A dark word inside the release gap must not close the pulse
        if (cur_release_gap > 0 && $urandom_range(0, 2) == 0) begin
            put_sample(dark_level(), t0 + ob + $urandom_range(0, cur_release_gap));
        end
        if (dur <= ob + cur_release_gap) dur = ob + cur_release_gap + 1;
        put_sample(dark_level(), t0 + dur);
        clock_us = t0 + dur;
        if ($urandom_range(0, 3) == 0) put_sample(dark_level(), clock_us + $urandom_range(0, 50000));
    endtask

    // Unshaped words, sometimes with a jump anywhere in the time range
    task automatic noise_run(input int count);
        repeat (count) begin
            if ($urandom_range(0, 2) == 0) clock_us = $urandom;
            else                           clock_us = clock_us + $urandom_range(0, 40000);
            put_sample(SAMPLE_W'($urandom_range(0, 4095)), clock_us);
        end
    endtask

    initial begin
        logic                en;
        logic [SAMPLE_W-1:0] thr;
        logic [GAP_W-1:0]    sg;
        logic [GAP_W-1:0]    rg;
        int                  phase;
        int                  w;
        int                  random_start;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Measuring off: a bright word only moves the last bright time
        put_sample(12'hFFF, 32'hFFFF_FFFF);
        put_sample(12'h000, 32'h0000_0000);
        settle();
        configure(1'b1, RST_LIGHT_THRESHOLD, RST_START_GAP, RST_RELEASE_GAP, 1'b0);
        // Bright too soon to start, then a dark word closing against the reset start time
        put_sample(12'd3000, 32'd5000);
        put_sample(RST_LIGHT_THRESHOLD, 32'd6000);
        // One pulse per window near either edge, a repeat, and a length on a window edge
        clock_us = 32'd20000;
        for (w = 0; w < NUM_WIN; w++) begin
            send_bare_pulse(w[0] ? WIN_HI[w] - 1 : WIN_LO[w] + 1);
        end
        send_bare_pulse((WIN_LO[NUM_WIN-1] + WIN_HI[NUM_WIN-1]) / 2);
        send_bare_pulse(WIN_LO[3]);

        random_start = samples_sent;
        for (phase = 0; samples_sent - random_start < RANDOM_SAMPLES; phase++) begin
            settle();
            gaps_on = ($urandom_range(0, 3) != 0);
            case (phase)
                0: configure(1'b1, '0, '0, '0, 1'b0);
                1: configure(1'b1, '1, GAP_MAX, GAP_MAX, 1'b0);
                2: configure(1'b0, SAMPLE_W'($urandom_range(1, 4094)), GAP_MAX, '0, 1'b1);
                default: begin
                    en = ($urandom_range(0, 5) != 0);
                    case ($urandom_range(0, 9))
                        0:       thr = '0;
                        1:       thr = '1;
                        default: thr = SAMPLE_W'($urandom_range(1, 4094));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       sg = GAP_MAX;
                        1:       sg = GAP_W'($urandom_range(0, 100));
                        default: sg = GAP_W'($urandom_range(20000, 120000));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       rg = GAP_MAX;
                        1:       rg = '0;
                        default: rg = GAP_W'($urandom_range(0, 8000));
                    endcase
                    configure(en, thr, sg, rg, $urandom_range(0, 3) == 0);
                end
            endcase
            // Move the time base, now and then close under the wrap
            if ($urandom_range(0, 3) == 0)      clock_us = $urandom;
            else if ($urandom_range(0, 7) == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 300000);
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 5) == 0) noise_run($urandom_range(1, 8));
                else                           run_pulse();
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
